/* rtl/spq_pkg.sv */
// ----------------------------------------------------------------------------
// spq_pkg - shared definitions for the sorted priority queue
// Queue depth, field widths, operation and status codes, controller states
// and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package spq_pkg;

    // queue geometry
    localparam int QUEUE_DEPTH = 16;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // field widths
    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int PRIO_W   = 16;
    localparam int STATUS_W = 3;

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_FLOOR   = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CEILING = 1'd1;

    localparam logic signed [PRIO_W-1:0] FLOOR_RESET   = 16'sd0;
    localparam logic signed [PRIO_W-1:0] CEILING_RESET = 16'sd32767;

    // operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OP_W-1:0] OP_LIST   = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STAT_INSERTED = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL     = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_EMPTY    = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_REMOVED  = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_LISTED   = 3'd5;

    // controller states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_RESP
    } spq_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_in;
        logic exec;
        logic list_step;
    } spq_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic no_result;
        logic out_last;
    } spq_sts_t;

endpackage

/* rtl/spq_ctrl.sv */
// ----------------------------------------------------------------------------
// spq_ctrl - sequencing for the sorted priority queue
// Takes an item, runs the execute state, then presents its results, if any,
// until the last one is taken; the next item may enter as the last result leaves.
// ----------------------------------------------------------------------------
module spq_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output spq_pkg::spq_cmd_t cmd,
    input  spq_pkg::spq_sts_t sts
);
    import spq_pkg::*;

    spq_state_t state_reg;
    spq_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        cmd.load_in   = 1'b0;
        cmd.exec      = 1'b0;
        cmd.list_step = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (sts.no_result)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                out_valid = 1'b1;
                in_ready  = out_ready && sts.out_last;
                if (out_ready)
                begin
                    if (!sts.out_last)
                    begin
                        cmd.list_step = 1'b1;
                    end
                    else if (in_valid)
                    begin
                        cmd.load_in = 1'b1;
                        state_next  = S_EXEC;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/spq_datapath.sv */
// ----------------------------------------------------------------------------
// spq_datapath - sorted cell chain, bounds and result register
// Each cell compares its priority with the pending item; insert shifts the
// upper part of the chain, remove takes the tail cell, list rotates the
// valid cells past cell 0 once per result.
// ----------------------------------------------------------------------------
module spq_datapath (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  spq_pkg::spq_cmd_t                       cmd,
    output spq_pkg::spq_sts_t                       sts,
    input  logic [spq_pkg::OP_W-1:0]                opcode,
    input  logic signed [spq_pkg::VALUE_W-1:0]      item_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]       item_priority,
    input  logic                                    cfg_we,
    input  logic [spq_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [spq_pkg::CFG_DATA_W-1:0]          cfg_wdata,
    output logic [spq_pkg::STATUS_W-1:0]            status,
    output logic signed [spq_pkg::VALUE_W-1:0]      out_value,
    output logic signed [spq_pkg::PRIO_W-1:0]       out_priority,
    output logic                                    last
);
    import spq_pkg::*;

    // pending item
    logic [OP_W-1:0]           op_reg, op_next;
    logic signed [VALUE_W-1:0] val_reg, val_next;
    logic signed [PRIO_W-1:0]  pri_reg, pri_next;

    // bounds
    logic signed [PRIO_W-1:0]  floor_reg, ceil_reg;

    // cell chain
    logic signed [VALUE_W-1:0] cell_val_reg  [QUEUE_DEPTH];
    logic signed [VALUE_W-1:0] cell_val_next [QUEUE_DEPTH];
    logic signed [PRIO_W-1:0]  cell_pri_reg  [QUEUE_DEPTH];
    logic signed [PRIO_W-1:0]  cell_pri_next [QUEUE_DEPTH];
    logic [CNT_W-1:0]          count_reg, count_next;
    logic [CNT_W-1:0]          list_idx_reg, list_idx_next;

    // result register
    logic [STATUS_W-1:0]       status_reg, status_next;
    logic signed [VALUE_W-1:0] oval_reg, oval_next;
    logic signed [PRIO_W-1:0]  opri_reg, opri_next;
    logic                      last_reg, last_next;

    // per-cell flags
    logic [QUEUE_DEPTH-1:0]    cell_valid;
    logic [QUEUE_DEPTH-1:0]    cell_ge;
    logic [QUEUE_DEPTH-1:0]    cell_le;
    logic [QUEUE_DEPTH-1:0]    cell_tail;
    logic [QUEUE_DEPTH-1:0]    at_or_after;
    logic                      go_front;
    logic                      go_end;
    logic                      range_ok;
    logic                      full;
    logic                      empty;
    logic signed [VALUE_W-1:0] tail_val;
    logic signed [PRIO_W-1:0]  tail_pri;
    logic signed [VALUE_W-1:0] rot_val [QUEUE_DEPTH];
    logic signed [PRIO_W-1:0]  rot_pri [QUEUE_DEPTH];

    // cell compares against the pending priority
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            cell_valid[i] = CNT_W'(i) < count_reg;
            cell_ge[i]    = cell_pri_reg[i] >= pri_reg;
            cell_le[i]    = cell_pri_reg[i] <= pri_reg;
        end
    end

    // tail of the valid run, one-hot
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
        begin
            cell_tail[i] = cell_valid[i] && !cell_valid[i+1];
        end
        cell_tail[QUEUE_DEPTH-1] = cell_valid[QUEUE_DEPTH-1];
    end

    // insert placement: cells at or after the new position
    assign empty    = count_reg == '0;
    assign full     = count_reg >= CNT_W'(QUEUE_DEPTH);
    assign range_ok = (pri_reg > floor_reg) && (pri_reg < ceil_reg);
    assign go_front = empty || cell_le[0] && !cell_ge[0] ? empty : (empty || cell_ge[0]);
    assign go_end   = &(~cell_valid | cell_le);

    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (go_front)
            begin
                at_or_after[i] = 1'b1;
            end
            else if (go_end)
            begin
                at_or_after[i] = !cell_valid[i];
            end
            else
            begin
                at_or_after[i] = cell_ge[i] || !cell_valid[i];
            end
        end
    end

    // tail select for remove
    always_comb
    begin
        tail_val = '0;
        tail_pri = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            tail_val = tail_val | (cell_val_reg[i] & {VALUE_W{cell_tail[i]}});
            tail_pri = tail_pri | (cell_pri_reg[i] & {PRIO_W{cell_tail[i]}});
        end
    end

    // rotate the valid cells down by one, cell 0 wraps to the tail
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH - 1; i++)
        begin
            if (cell_valid[i+1])
            begin
                rot_val[i] = cell_val_reg[i+1];
                rot_pri[i] = cell_pri_reg[i+1];
            end
            else if (cell_valid[i])
            begin
                rot_val[i] = cell_val_reg[0];
                rot_pri[i] = cell_pri_reg[0];
            end
            else
            begin
                rot_val[i] = cell_val_reg[i];
                rot_pri[i] = cell_pri_reg[i];
            end
        end
        if (cell_valid[QUEUE_DEPTH-1])
        begin
            rot_val[QUEUE_DEPTH-1] = cell_val_reg[0];
            rot_pri[QUEUE_DEPTH-1] = cell_pri_reg[0];
        end
        else
        begin
            rot_val[QUEUE_DEPTH-1] = cell_val_reg[QUEUE_DEPTH-1];
            rot_pri[QUEUE_DEPTH-1] = cell_pri_reg[QUEUE_DEPTH-1];
        end
    end

    // next-state logic of the datapath
    always_comb
    begin
        op_next       = op_reg;
        val_next      = val_reg;
        pri_next      = pri_reg;
        count_next    = count_reg;
        list_idx_next = list_idx_reg;
        status_next   = status_reg;
        oval_next     = oval_reg;
        opri_next     = opri_reg;
        last_next     = last_reg;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            cell_val_next[i] = cell_val_reg[i];
            cell_pri_next[i] = cell_pri_reg[i];
        end

        if (cmd.load_in)
        begin
            op_next  = opcode;
            val_next = item_value;
            pri_next = item_priority;
        end

        if (cmd.exec)
        begin
            oval_next = '0;
            opri_next = '0;
            last_next = 1'b1;
            case (op_reg)
                OP_INSERT:
                begin
                    if (!range_ok)
                    begin
                        status_next = STAT_RANGE;
                    end
                    else if (full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        status_next = STAT_INSERTED;
                        count_next  = count_reg + 1'b1;
                        for (int i = 0; i < QUEUE_DEPTH; i++)
                        begin
                            if (i == 0)
                            begin
                                if (at_or_after[0])
                                begin
                                    cell_val_next[0] = val_reg;
                                    cell_pri_next[0] = pri_reg;
                                end
                            end
                            else if (at_or_after[i] && !at_or_after[i-1])
                            begin
                                cell_val_next[i] = val_reg;
                                cell_pri_next[i] = pri_reg;
                            end
                            else if (at_or_after[i])
                            begin
                                cell_val_next[i] = cell_val_reg[i-1];
                                cell_pri_next[i] = cell_pri_reg[i-1];
                            end
                        end
                    end
                end
                OP_REMOVE:
                begin
                    if (empty)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        status_next = STAT_REMOVED;
                        oval_next   = tail_val;
                        opri_next   = tail_pri;
                        count_next  = count_reg - 1'b1;
                    end
                end
                OP_LIST:
                begin
                    if (empty)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        status_next   = STAT_LISTED;
                        oval_next     = cell_val_reg[0];
                        opri_next     = cell_pri_reg[0];
                        last_next     = count_reg == CNT_W'(1);
                        list_idx_next = CNT_W'(1);
                        for (int i = 0; i < QUEUE_DEPTH; i++)
                        begin
                            cell_val_next[i] = rot_val[i];
                            cell_pri_next[i] = rot_pri[i];
                        end
                    end
                end
                default:
                begin
                    last_next = last_reg;
                end
            endcase
        end

        // next listed entry
        if (cmd.list_step)
        begin
            status_next   = STAT_LISTED;
            oval_next     = cell_val_reg[0];
            opri_next     = cell_pri_reg[0];
            last_next     = (list_idx_reg + 1'b1) == count_reg;
            list_idx_next = list_idx_reg + 1'b1;
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                cell_val_next[i] = rot_val[i];
                cell_pri_next[i] = rot_pri[i];
            end
        end
    end

    // control state and bounds
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg    <= '0;
            list_idx_reg <= '0;
            floor_reg    <= FLOOR_RESET;
            ceil_reg     <= CEILING_RESET;
        end
        else
        begin
            count_reg    <= count_next;
            list_idx_reg <= list_idx_next;
            if (cfg_we && cfg_index == CFG_FLOOR)
            begin
                floor_reg <= cfg_wdata;
            end
            if (cfg_we && cfg_index == CFG_CEILING)
            begin
                ceil_reg <= cfg_wdata;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        val_reg    <= val_next;
        pri_reg    <= pri_next;
        status_reg <= status_next;
        oval_reg   <= oval_next;
        opri_reg   <= opri_next;
        last_reg   <= last_next;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            cell_val_reg[i] <= cell_val_next[i];
            cell_pri_reg[i] <= cell_pri_next[i];
        end
    end

    // status to the controller
    always_comb
    begin
        sts.out_last = last_reg;
        case (op_reg)
            OP_INSERT, OP_REMOVE, OP_LIST: sts.no_result = 1'b0;
            default:                       sts.no_result = 1'b1;
        endcase
    end

    assign status       = status_reg;
    assign out_value    = oval_reg;
    assign out_priority = opri_reg;
    assign last         = last_reg;

`ifndef SYNTHESIS
    // the entry count stays within the chain
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("entry count beyond queue depth");

    // an accepted insert adds exactly one entry
    a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec && op_reg == OP_INSERT && range_ok && !full
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not grow the queue by one");

    // a list step only happens inside a non-empty listing
    a_list_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.list_step |-> list_idx_reg != '0 && list_idx_reg < count_reg)
        else $error("list step outside the valid entries");

    // a list step never runs alongside an execute cycle
    a_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.exec && cmd.list_step))
        else $error("execute and list step at once");
`endif

endmodule

/* rtl/sorted_priority_queue.sv */
// ----------------------------------------------------------------------------
// sorted_priority_queue - bounded priority queue on a sorted cell chain
// Insert, remove-highest and list-all on up to QUEUE_DEPTH entries kept in
// ascending priority order, with configurable exclusive priority bounds.
// ----------------------------------------------------------------------------
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  input    | in_valid / in_ready  | opcode, item_value, item_priority
//  output   | out_valid / out_ready| status, out_value, out_priority, last
//  config   | cfg_we               | cfg_index, cfg_wdata
//
//  An insert or remove first registers the item, then runs the
//  compare-and-shift across all cells; the next item enters in the cycle
//  its result is taken. A list makes one rotation of the cell chain per
//  entry. Opcode 3 gives no result. Reset clears the entry count and sets
//  the floor to 0 and the ceiling to 32767; no clearing pass is needed.
//  A stalled output holds its result and the block takes no new item.
//
module sorted_priority_queue (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [spq_pkg::OP_W-1:0]            opcode,
    input  logic signed [spq_pkg::VALUE_W-1:0]  item_value,
    input  logic signed [spq_pkg::PRIO_W-1:0]   item_priority,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [spq_pkg::STATUS_W-1:0]        status,
    output logic signed [spq_pkg::VALUE_W-1:0]  out_value,
    output logic signed [spq_pkg::PRIO_W-1:0]   out_priority,
    output logic                                last,
    input  logic                                cfg_we,
    input  logic [spq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [spq_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import spq_pkg::*;

    spq_cmd_t cmd;
    spq_sts_t sts;

    // sequencing
    spq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // cell chain and result register
    spq_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .opcode        (opcode),
        .item_value    (item_value),
        .item_priority (item_priority),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .status        (status),
        .out_value     (out_value),
        .out_priority  (out_priority),
        .last          (last)
    );

endmodule
